[hw/rtl/pressure_temperature_compensation_top_assert.svh]
// ============================================================================
// Assertion macros for the compensation block
// Shared clocked assertion forms used by the port checker.
// ============================================================================
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_TOP_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_TOP_ASSERT_SVH

// Clocked assertion, masked while reset is active
`define PTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled item keeps its valid and its payload
`define PTC_ASSERT_HOLD(label, vld, rdy, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> (vld && $stable(sig))) else $error("stalled item changed");

`endif

[hw/rtl/ptc_pkg.sv]
// ============================================================================
// ptc_pkg
// Types and constants shared by the compensation block modules.
// ============================================================================
package ptc_pkg;

    localparam int RAW_W     = 20;
    localparam int CALIB_W   = 48;
    localparam int CFG_IDX_W = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_A    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_B    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_C    = 3'd3;

    // Formula constants
    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] PRESS_FULL  = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE = 64'd3125;
    localparam logic [63:0] ROUND_47    = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic [RAW_W-1:0] adc_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } item_t;

    typedef struct packed {
        logic [31:0] pressure_q24_8;
        logic [31:0] fine_temperature;
        logic [31:0] temperature_centi;
        logic        pressure_invalid;
    } result_t;

    typedef struct packed {
        logic [CALIB_W-1:0] press_calib_c;
        logic [CALIB_W-1:0] press_calib_b;
        logic [CALIB_W-1:0] press_calib_a;
        logic [CALIB_W-1:0] temp_calib;
    } calib_t;

    // Sign-extend a 16-bit calibration word to 64 bits
    function automatic logic [63:0] sext16(input logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

endpackage

[hw/rtl/pressure_temperature_compensation_top.sv]
// ============================================================================
// pressure_temperature_compensation_top
// Integer temperature and pressure compensation of raw converter readings.
// ============================================================================
// Each item carries a raw temperature and a raw pressure reading and yields
// one result: temperature in 0.01 degC, the fine temperature, and pressure in
// Pa as unsigned Q24.8, with tuser set when the pressure divisor is zero
// (pressure then reads 0). The sequencer takes one item at a time from the
// queue and runs thirteen 64-bit products, each of operand load, three partial
// products and hand-off, on a single shared 32 x 32 multiplier, and a
// bit-serial divide (load, 64 quotient bits, hand-off), then loads the result
// register; a zero divisor skips the divide and the last four products. A short
// input queue takes new items while one is computed, and a result register
// holds the finished item until taken; a stalled result holds the sequencer.
// Calibration registers 0..3 are to be written through the cfg port only while
// no item is in flight; the block itself does not enforce this.
// ============================================================================
module pressure_temperature_compensation_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: raw_temperature [19:0], adc_pressure [39:20]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    // m_tdata: temperature_centi [31:0], fine_temperature [63:32],
    //          pressure_q24_8 [95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,
    // m_tuser: pressure_invalid [0]
    output logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [ptc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptc_pkg::CALIB_W-1:0]   cfg_data
);
    import ptc_pkg::*;

    calib_t  calib_reg;
    item_t   in_item;
    item_t   q_item;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    result_t res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign in_item.raw_temperature = s_tdata[19:0];
    assign in_item.adc_pressure    = s_tdata[39:20];

    // Write calibration registers, drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            calib_reg <= '0;
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_TEMP_CALIB)
                calib_reg.temp_calib <= cfg_data;
            if (cfg_index == REG_PRESS_A)
                calib_reg.press_calib_a <= cfg_data;
            if (cfg_index == REG_PRESS_B)
                calib_reg.press_calib_b <= cfg_data;
            if (cfg_index == REG_PRESS_C)
                calib_reg.press_calib_c <= cfg_data;
        end
    end

    ptc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_data (in_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_item),
        .empty     (q_empty)
    );

    ptc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (!q_empty),
        .item       (q_item),
        .item_pop   (q_pop),
        .calib      (calib_reg),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {res.pressure_q24_8, res.fine_temperature, res.temperature_centi};
    assign m_tuser = res.pressure_invalid;

endmodule

[hw/rtl/ptc_fifo.sv]
// ============================================================================
// ptc_fifo
// Short item queue between the input side and the compute sequencer.
// ============================================================================
module ptc_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ptc_pkg::item_t push_data,
    output logic           full,
    input  logic           pop,
    output ptc_pkg::item_t pop_data,
    output logic           empty
);
    import ptc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store the item
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

[hw/rtl/ptc_mul64.sv]
// ============================================================================
// ptc_mul64
// Low 64 bits of a 64 x 64 product from one 32 x 32 multiplier, built from
// three partial products.
// ============================================================================
module ptc_mul64 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] product
);
    logic [1:0]  phase_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] prod_reg;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;

    // Pick the partial product for this phase
    always_comb
    begin
        unique case (phase_reg)
            2'd0:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[31:0];
            end
            2'd1:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[63:32];
            end
            default:
            begin
                mul_x = a_reg[63:32];
                mul_y = b_reg[31:0];
            end
        endcase
    end

    assign mul_p   = {32'b0, mul_x} * {32'b0, mul_y};
    assign done    = done_reg;
    assign product = prod_reg;

    // Sequence the phases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                if (phase_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                phase_reg <= phase_reg + 2'd1;
            end
        end
    end

    // Accumulate partial products
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            if (phase_reg == 2'd0)
                prod_reg <= mul_p;
            else
                prod_reg[63:32] <= prod_reg[63:32] + mul_p[31:0];
        end
    end

endmodule

[hw/rtl/ptc_div64.sv]
// ============================================================================
// ptc_div64
// Signed 64-bit division truncating toward zero, one quotient bit a cycle.
// ============================================================================
module ptc_div64 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quotient
);
    localparam logic [5:0] LAST_STEP = 6'd63;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  count_reg;
    logic [63:0] rem_reg;
    logic [63:0] q_reg;
    logic [63:0] md_reg;
    logic        neg_reg;
    logic [64:0] rem_sh;
    logic [64:0] diff;
    logic        ge;

    assign rem_sh   = {rem_reg, q_reg[63]};
    assign diff     = rem_sh - {1'b0, md_reg};
    assign ge       = !diff[64];
    assign done     = done_reg;
    assign quotient = neg_reg ? (64'd0 - q_reg) : q_reg;

    // Count the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 6'd1;
                if (count_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Take magnitudes, then shift and subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[63] ^ den[63];
            q_reg   <= num[63] ? (64'd0 - num) : num;
            md_reg  <= den[63] ? (64'd0 - den) : den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[63:0] : rem_sh[63:0];
            q_reg   <= {q_reg[62:0], ge};
        end
    end

endmodule

[hw/rtl/ptc_back.sv]
// ============================================================================
// ptc_back
// Compute sequencer: runs the compensation formulas on one item at a time
// over a shared multiplier and divider, and holds the result for output.
// ============================================================================
module ptc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  ptc_pkg::item_t    item,
    output logic              item_pop,
    input  ptc_pkg::calib_t   calib,
    output logic              res_valid,
    input  logic              res_ready,
    output ptc_pkg::result_t  res
);
    import ptc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TA, ST_TD, ST_TB, ST_V11, ST_V26, ST_V25, ST_V13,
        ST_V12, ST_V1P1, ST_NUM, ST_DIV, ST_PS, ST_W1, ST_W2, ST_DONE
    } step_t;

    step_t       step_reg;
    step_t       step_next;
    logic        issued_reg;
    logic        res_valid_reg;
    result_t     res_reg;

    logic [19:0] adc_t_reg;
    logic [19:0] adc_p_reg;
    logic [31:0] a_reg;
    logic [31:0] tmp_reg;
    logic [31:0] fine_reg;
    logic [31:0] temp_reg;
    logic [63:0] v1_reg;
    logic [63:0] m1_reg;
    logic [63:0] v2_reg;
    logic [63:0] acc_reg;
    logic [63:0] p_reg;
    logic [31:0] pres_reg;
    logic        inv_reg;

    logic        is_mul_step;
    logic        mul_start;
    logic        mul_done;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic [63:0] mul_p;
    logic        div_start;
    logic        div_done;
    logic [63:0] div_q;

    logic [31:0] t1;
    logic [31:0] x1;
    logic [31:0] d;
    logic [31:0] b_val;
    logic [31:0] fine_sum;
    logic [31:0] fine5;
    logic [63:0] den_val;
    logic [63:0] num_pre;
    logic [63:0] ps;
    logic [63:0] sum_p;

    // Operands derived from the item and calibration
    assign t1      = {16'b0, calib.temp_calib[15:0]};
    assign x1      = 32'({12'b0, adc_t_reg} >> 3) - (t1 << 1);
    assign d       = 32'({12'b0, adc_t_reg} >> 4) - t1;
    assign b_val   = 32'($signed(mul_p[31:0]) >>> 14);
    assign fine_sum = a_reg + b_val;
    assign fine5   = fine_sum + (fine_sum << 2) + 32'd128;
    assign den_val = 64'($signed(mul_p) >>> 33);
    assign num_pre = ((PRESS_FULL - {44'b0, adc_p_reg}) << 31) - v2_reg;
    assign ps      = 64'($signed(p_reg) >>> 13);
    assign sum_p   = p_reg + v2_reg + 64'($signed(mul_p) >>> 19);

    // Select multiplier operands per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (step_reg)
            ST_TA:   begin mul_a = {32'b0, x1}; mul_b = sext16(calib.temp_calib[31:16]); end
            ST_TD:   begin mul_a = {32'b0, d}; mul_b = {32'b0, d}; end
            ST_TB:
            begin
                mul_a = {32'b0, 32'($signed(tmp_reg) >>> 12)};
                mul_b = sext16(calib.temp_calib[47:32]);
            end
            ST_V11:  begin mul_a = v1_reg; mul_b = v1_reg; end
            ST_V26:  begin mul_a = m1_reg; mul_b = sext16(calib.press_calib_b[47:32]); end
            ST_V25:  begin mul_a = v1_reg; mul_b = sext16(calib.press_calib_b[31:16]); end
            ST_V13:  begin mul_a = m1_reg; mul_b = sext16(calib.press_calib_a[47:32]); end
            ST_V12:  begin mul_a = v1_reg; mul_b = sext16(calib.press_calib_a[31:16]); end
            ST_V1P1: begin mul_a = acc_reg; mul_b = {48'b0, calib.press_calib_a[15:0]}; end
            ST_NUM:  begin mul_a = num_pre; mul_b = PRESS_SCALE; end
            ST_PS:   begin mul_a = ps; mul_b = ps; end
            ST_W1:   begin mul_a = m1_reg; mul_b = sext16(calib.press_calib_c[47:32]); end
            ST_W2:   begin mul_a = p_reg; mul_b = sext16(calib.press_calib_c[31:16]); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Order of the steps
    always_comb
    begin
        unique case (step_reg)
            ST_IDLE: step_next = ST_TA;
            ST_TA:   step_next = ST_TD;
            ST_TD:   step_next = ST_TB;
            ST_TB:   step_next = ST_V11;
            ST_V11:  step_next = ST_V26;
            ST_V26:  step_next = ST_V25;
            ST_V25:  step_next = ST_V13;
            ST_V13:  step_next = ST_V12;
            ST_V12:  step_next = ST_V1P1;
            ST_V1P1: step_next = (den_val == '0) ? ST_DONE : ST_NUM;
            ST_NUM:  step_next = ST_DIV;
            ST_DIV:  step_next = ST_PS;
            ST_PS:   step_next = ST_W1;
            ST_W1:   step_next = ST_W2;
            ST_W2:   step_next = ST_DONE;
            default: step_next = ST_IDLE;
        endcase
    end

    assign is_mul_step = (step_reg != ST_IDLE) && (step_reg != ST_DIV) &&
                         (step_reg != ST_DONE);
    assign mul_start   = is_mul_step && !issued_reg;
    assign div_start   = (step_reg == ST_DIV) && !issued_reg;
    assign item_pop    = (step_reg == ST_IDLE) && item_valid;
    assign res_valid   = res_valid_reg;
    assign res         = res_reg;

    ptc_mul64 u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    ptc_div64 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (m1_reg),
        .den      (acc_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequence steps and hand off the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_IDLE;
            issued_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
                res_valid_reg <= 1'b0;
            unique case (step_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                        step_reg <= step_next;
                end
                ST_DIV:
                begin
                    if (div_start)
                        issued_reg <= 1'b1;
                    if (div_done)
                    begin
                        issued_reg <= 1'b0;
                        step_reg   <= step_next;
                    end
                end
                ST_DONE:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_valid_reg <= 1'b1;
                        step_reg      <= step_next;
                    end
                end
                default:
                begin
                    if (mul_start)
                        issued_reg <= 1'b1;
                    if (mul_done)
                    begin
                        issued_reg <= 1'b0;
                        step_reg   <= step_next;
                    end
                end
            endcase
        end
    end

    // Capture intermediates as each step completes
    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            adc_t_reg <= item.raw_temperature;
            adc_p_reg <= item.adc_pressure;
        end
        if (step_reg == ST_DIV && div_done)
            p_reg <= div_q;
        if (step_reg == ST_DONE && (!res_valid_reg || res_ready))
        begin
            res_reg.temperature_centi <= temp_reg;
            res_reg.fine_temperature  <= fine_reg;
            res_reg.pressure_q24_8    <= pres_reg;
            res_reg.pressure_invalid  <= inv_reg;
        end
        if (mul_done)
        begin
            unique case (step_reg)
                ST_TA:   a_reg   <= 32'($signed(mul_p[31:0]) >>> 11);
                ST_TD:   tmp_reg <= mul_p[31:0];
                ST_TB:
                begin
                    fine_reg <= fine_sum;
                    temp_reg <= 32'($signed(fine5) >>> 8);
                    v1_reg   <= {{32{fine_sum[31]}}, fine_sum} - FINE_OFFSET;
                end
                ST_V11:  m1_reg  <= mul_p;
                ST_V26:  v2_reg  <= mul_p;
                ST_V25:
                begin
                    v2_reg <= v2_reg + (mul_p << 17) +
                              (sext16(calib.press_calib_b[15:0]) << 35);
                end
                ST_V13:  acc_reg <= 64'($signed(mul_p) >>> 8);
                ST_V12:  acc_reg <= acc_reg + (mul_p << 12) + ROUND_47;
                ST_V1P1:
                begin
                    acc_reg  <= den_val;
                    inv_reg  <= (den_val == '0);
                    pres_reg <= '0;
                end
                ST_NUM:  m1_reg  <= mul_p;
                ST_PS:   m1_reg  <= mul_p;
                ST_W1:   v2_reg  <= 64'($signed(mul_p) >>> 25);
                ST_W2:
                begin
                    pres_reg <= 32'(64'($signed(sum_p) >>> 8) +
                                    (sext16(calib.press_calib_c[15:0]) << 4));
                end
                default: ;
            endcase
        end
    end

endmodule

[hw/rtl/ptc_checker.sv]
// ============================================================================
// ptc_checker
// Port-level checks of the compensation block, bound to its top level.
// ============================================================================
`include "pressure_temperature_compensation_top_assert.svh"

module ptc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready
);
    logic [31:0] temp_from_fine;
    logic        pres_zero;

    assign temp_from_fine = 32'($signed(32'(m_tdata[63:32] * 32'd5 + 32'd128)) >>> 8);
    assign pres_zero      = (m_tdata[95:64] == 32'd0);

    // Hold a stalled input item
    `PTC_ASSERT_HOLD(a_in_hold, s_tvalid, s_tready, s_tdata)

    // Hold a stalled result
    `PTC_ASSERT_HOLD(a_res_hold, m_tvalid, m_tready, m_tdata)

    // Invalid pressure reads as zero
    `PTC_ASSERT(a_inv_zero, (m_tvalid && m_tuser[0]) |-> pres_zero, "invalid pressure not zero")

    // Temperature follows from fine temperature
    `PTC_ASSERT(a_temp_fine, m_tvalid |-> (m_tdata[31:0] == temp_from_fine), "temperature mismatch")

    // Configuration is always taken
    `PTC_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "config write refused")

endmodule

bind pressure_temperature_compensation_top ptc_checker u_checker (.*);
